// File: rtl/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg: shared types and constants of the chained hash set
// Widths of the key, node index and bucket index, and the item passed from
// the front end to the back end.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int MaxBuckets = 256;
  localparam int PoolNodes  = 1024;
  localparam int KeyBits    = 32;
  localparam int BktW       = $clog2(MaxBuckets);
  localparam int NodeW      = $clog2(PoolNodes);
  localparam int CntW       = NodeW + 1;
  localparam int CfgW       = 9;

  localparam logic [1:0] ModeInsert = 2'd0;
  localparam logic [1:0] ModeFind   = 2'd1;
  localparam logic [1:0] ModeClear  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [KeyBits-1:0] key;
    logic [BktW-1:0]    bucket;
  } item_t;

endpackage

// File: rtl/chs_front.sv
// ----------------------------------------------------------------------------
// chs_front: item intake and bucket selection
// Takes an item; unless it is a clear, reduces the key modulo the bucket
// count by restoring subtraction, one quotient bit per cycle, then queues it.
// ----------------------------------------------------------------------------
module chs_front import chs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         mode_i,
  input  logic [KeyBits-1:0] key_i,
  input  logic [CfgW-1:0]    bucket_count_i,
  output logic               ready_o,
  output logic               out_valid_o,
  output item_t              out_item_o,
  input  logic               out_ready_i
);

  localparam int StepW = $clog2(KeyBits + 1);

  typedef enum logic [1:0] {FsIdle, FsDiv, FsOut} fstate_e;

  fstate_e            state_q;
  logic [StepW-1:0]   step_q;
  logic [1:0]         mode_q;
  logic [KeyBits-1:0] key_q;
  logic [KeyBits-1:0] quo_q;
  logic [CfgW:0]      rem_q;
  logic [CfgW-1:0]    div_q;
  logic [CfgW:0]      trial;
  logic [CfgW-1:0]    div_sat;

  // Zero acts as one, counts above the bucket array saturate.
  always_comb begin
    div_sat = bucket_count_i;
    if (bucket_count_i == '0) div_sat = CfgW'(1);
    else if (bucket_count_i > CfgW'(MaxBuckets)) div_sat = CfgW'(MaxBuckets);
  end

  assign trial = {rem_q[CfgW-1:0], quo_q[KeyBits-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsIdle;
      step_q  <= '0;
    end else begin
      case (state_q)
        FsIdle: begin
          if (start_i) begin
            mode_q  <= mode_i;
            key_q   <= key_i;
            quo_q   <= key_i;
            rem_q   <= '0;
            div_q   <= div_sat;
            step_q  <= '0;
            state_q <= (mode_i == ModeClear) ? FsOut : FsDiv;
          end
        end
        FsDiv: begin
          quo_q <= {quo_q[KeyBits-2:0], 1'b0};
          if (trial >= {1'b0, div_q}) rem_q <= trial - {1'b0, div_q};
          else rem_q <= trial;
          if (step_q == StepW'(KeyBits - 1)) state_q <= FsOut;
          step_q <= step_q + 1'b1;
        end
        FsOut: begin
          if (out_ready_i) state_q <= FsIdle;
        end
        default: state_q <= FsIdle;
      endcase
    end
  end

  assign ready_o          = (state_q == FsIdle);
  assign out_valid_o      = (state_q == FsOut);
  assign out_item_o.mode  = mode_q;
  assign out_item_o.key   = key_q;
  assign out_item_o.bucket = rem_q[BktW-1:0];

endmodule

// File: rtl/chs_queue.sv
// ----------------------------------------------------------------------------
// chs_queue: two-entry queue between front and back end
// Lets the front end divide the next key while the back end walks a chain.
// ----------------------------------------------------------------------------
module chs_queue import chs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  item_t in_item_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  output item_t out_item_o,
  input  logic  out_ready_i
);

  item_t       mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/chs_back.sv
// ----------------------------------------------------------------------------
// chs_back: table storage and chain walker
// Holds the bucket heads, the node pool and the count. Insert links a new
// node at the chain head; find walks the chain one node per memory read.
// ----------------------------------------------------------------------------
module chs_back import chs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  item_t        in_item_i,
  output logic         in_ready_o,
  output logic         done_o,
  output logic         hit_o,
  output logic         overflow_o,
  output logic [CntW-1:0] node_count_o
);

  typedef enum logic [2:0] {BsIdle, BsHead, BsRead, BsCmp, BsDone} bstate_e;

  bstate_e          state_q;
  item_t            item_q;
  logic [NodeW-1:0] head_q [MaxBuckets];
  logic [MaxBuckets-1:0] hvalid_q;
  logic [NodeW-1:0] cur_q;
  logic [CntW-1:0]  count_q;
  logic             hit_q, ovf_q;

  // Node pool, one read port with registered data.
  logic [KeyBits-1:0] nkey_mem [PoolNodes];
  logic [NodeW:0]     nnext_mem [PoolNodes];   // {valid, index}
  logic [KeyBits-1:0] rkey_q;
  logic [NodeW:0]     rnext_q;
  logic               wr_en;
  logic [NodeW-1:0]   wr_addr;
  logic [NodeW-1:0]   hd_q;
  logic               hdv_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      nkey_mem[wr_addr]  <= item_q.key;
      nnext_mem[wr_addr] <= {hdv_q, hd_q};
    end
    rkey_q  <= nkey_mem[cur_q];
    rnext_q <= nnext_mem[cur_q];
  end

  assign wr_addr = count_q[NodeW-1:0];
  assign wr_en   = (state_q == BsHead) && (item_q.mode == ModeInsert)
                   && (count_q < CntW'(PoolNodes));

  always_ff @(posedge clk_i) begin
    if (state_q == BsIdle && in_valid_i) begin
      hd_q <= head_q[in_item_i.bucket];
      if (wr_en) head_q[item_q.bucket] <= wr_addr;
    end else if (wr_en) begin
      head_q[item_q.bucket] <= wr_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BsIdle;
      hvalid_q <= '0;
      count_q  <= '0;
      hit_q    <= 1'b0;
      ovf_q    <= 1'b0;
      hdv_q    <= 1'b0;
      cur_q    <= '0;
    end else begin
      case (state_q)
        BsIdle: begin
          if (in_valid_i) begin
            item_q  <= in_item_i;
            hdv_q   <= hvalid_q[in_item_i.bucket];
            hit_q   <= 1'b0;
            ovf_q   <= 1'b0;
            state_q <= BsHead;
          end
        end
        BsHead: begin
          case (item_q.mode)
            ModeInsert: begin
              if (count_q < CntW'(PoolNodes)) begin
                hvalid_q[item_q.bucket] <= 1'b1;
                count_q <= count_q + 1'b1;
              end else begin
                ovf_q <= 1'b1;
              end
              state_q <= BsDone;
            end
            ModeFind: begin
              cur_q   <= hd_q;
              state_q <= hdv_q ? BsRead : BsDone;
            end
            ModeClear: begin
              hvalid_q <= '0;
              count_q  <= '0;
              state_q  <= BsDone;
            end
            default: state_q <= BsDone;
          endcase
        end
        BsRead: state_q <= BsCmp;
        BsCmp: begin
          if (rkey_q == item_q.key) begin
            hit_q   <= 1'b1;
            state_q <= BsDone;
          end else if (!rnext_q[NodeW]) begin
            state_q <= BsDone;
          end else begin
            cur_q   <= rnext_q[NodeW-1:0];
            state_q <= BsRead;
          end
        end
        BsDone: state_q <= BsIdle;
        default: state_q <= BsIdle;
      endcase
    end
  end

  assign in_ready_o   = (state_q == BsIdle);
  assign done_o       = (state_q == BsDone);
  assign hit_o        = hit_q;
  assign overflow_o   = ovf_q;
  assign node_count_o = count_q;

endmodule

// File: rtl/chained_hash_set.sv
// ----------------------------------------------------------------------------
// chained_hash_set: hash set of keys with separately chained buckets
// Front end, item queue and table back end.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. Every item gives
// exactly one result, shown for one cycle with done_o high; the receiver
// cannot stall it. The bucket is found by a bit-serial divider, skipped for
// a clear, and the back end then handles the item, with one node-pool read
// per chain node visited on a find. The two ends overlap through a two-entry
// queue, so sustained rate is set by the slower of the divider and chain walk.
// The bucket count (cfg_we_i, cfg_wdata_i) may be written only while no item
// is in flight.
module chained_hash_set import chs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         mode_i,
  input  logic [KeyBits-1:0] key_i,
  input  logic               cfg_we_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output logic               done_o,
  output logic               hit_o,
  output logic               overflow_o,
  output logic [CntW-1:0]    node_count_o
);

  logic [CfgW-1:0] bucket_count_q;
  logic  f_ready, f_valid, q_in_ready, q_valid, b_ready;
  item_t f_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bucket_count_q <= CfgW'(97);
    else if (cfg_we_i) bucket_count_q <= cfg_wdata_i;
  end

  assign busy_o = !f_ready;

  chs_front u_front (
    .clk_i, .rst_ni, .start_i, .mode_i, .key_i,
    .bucket_count_i(bucket_count_q), .ready_o(f_ready),
    .out_valid_o(f_valid), .out_item_o(f_item), .out_ready_i(q_in_ready)
  );

  chs_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(f_valid), .in_item_i(f_item),
    .in_ready_o(q_in_ready), .out_valid_o(q_valid), .out_item_o(q_item),
    .out_ready_i(b_ready)
  );

  chs_back u_back (
    .clk_i, .rst_ni, .in_valid_i(q_valid), .in_item_i(q_item),
    .in_ready_o(b_ready), .done_o, .hit_o, .overflow_o, .node_count_o
  );

endmodule

// File: dv/tb_chained_hash_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_hash_set: self-checking testbench of the chained hash set
// A queue of pending items and bucket count writes drives the block. A
// behavioural copy of the table predicts hit, overflow and node count for
// every item, and a monitor checks each result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_chained_hash_set;
  import chs_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;

  typedef struct {
    bit                 is_cfg;
    logic [CfgW-1:0]    cfg;
    logic [1:0]         mode;
    logic [KeyBits-1:0] key;
  } op_t;

  typedef struct {
    logic            hit;
    logic            overflow;
    logic [CntW-1:0] count;
  } outcome_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         mode_i = '0;
  logic [KeyBits-1:0] key_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               done_o;
  logic               hit_o;
  logic               overflow_o;
  logic [CntW-1:0]    node_count_o;

  chained_hash_set dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the table.
  logic [NodeW-1:0]   head_idx [MaxBuckets];
  bit                 head_ok  [MaxBuckets];
  logic [NodeW-1:0]   link_idx [PoolNodes];
  bit                 link_ok  [PoolNodes];
  logic [KeyBits-1:0] pool_key [PoolNodes];
  int                 stored;
  int                 buckets_cfg = 97;

  op_t                pending_ops[$];
  outcome_t           expected_outcomes[$];
  logic [KeyBits-1:0] seen_keys[$];
  int                 n_taken = 0;
  int                 n_returned = 0;
  int                 n_errors = 0;
  bit                 stimulus_done = 1'b0;

  function automatic int bucket_of(logic [KeyBits-1:0] k);
    int n;
    n = buckets_cfg;
    if (n == 0) n = 1;
    if (n > MaxBuckets) n = MaxBuckets;
    return int'(k % n);
  endfunction

  function automatic outcome_t apply_to_table(logic [1:0] mode, logic [KeyBits-1:0] k);
    outcome_t r;
    int b;
    int cur;
    r = '{1'b0, 1'b0, '0};
    b = bucket_of(k);
    case (mode)
      ModeInsert: begin
        if (stored >= PoolNodes) begin
          r.overflow = 1'b1;
        end else begin
          pool_key[stored] = k;
          link_idx[stored] = head_idx[b];
          link_ok[stored]  = head_ok[b];
          head_idx[b] = stored[NodeW-1:0];
          head_ok[b]  = 1'b1;
          stored++;
        end
      end
      ModeFind: begin
        if (head_ok[b]) begin
          cur = head_idx[b];
          for (int s = 0; s < PoolNodes; s++) begin
            if (pool_key[cur] == k) begin
              r.hit = 1'b1;
              break;
            end
            if (!link_ok[cur]) break;
            cur = link_idx[cur];
          end
        end
      end
      ModeClear: begin
        foreach (head_ok[i]) head_ok[i] = 1'b0;
        stored = 0;
      end
      default: ;
    endcase
    r.count = stored[CntW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t: result %0d %s = %0d, expected %0d",
             $realtime, n_returned, what, got, want);
    n_errors++;
  endtask

  // Driver. Bucket count writes wait until every result is back.
  int settle = 0;
  always @(posedge clk_i) begin
    bit nxt_start;
    bit nxt_we;
    bit accepted;
    int taken_now;
    nxt_start = start_i;
    nxt_we    = 1'b0;
    accepted  = start_i && !busy_o;
    taken_now = n_taken;
    if (rst_ni) begin
      if (accepted) begin
        expected_outcomes.push_back(apply_to_table(mode_i, key_i));
        void'(pending_ops.pop_front());
        taken_now++;
        n_taken <= taken_now;
      end
      if (accepted || !start_i) begin
        nxt_start = 1'b0;
        if (pending_ops.size() == 0) begin
          stimulus_done <= 1'b1;
        end else if (pending_ops[0].is_cfg) begin
          if (taken_now != n_returned || accepted) begin
            settle <= 0;
          end else if (settle < 4) begin
            settle <= settle + 1;
          end else begin
            nxt_we = 1'b1;
            cfg_wdata_i <= pending_ops[0].cfg;
            buckets_cfg = pending_ops[0].cfg;
            void'(pending_ops.pop_front());
            settle <= 0;
          end
        end else if ((taken_now >= 700 && taken_now < 1000) || $urandom_range(99) >= 15) begin
          nxt_start = 1'b1;
          mode_i <= pending_ops[0].mode;
          key_i  <= pending_ops[0].key;
        end
      end
    end
    start_i  <= nxt_start;
    cfg_we_i <= nxt_we;
  end

  // Monitor.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (expected_outcomes.size() == 0) begin
        $display("ERROR at %0t: result with no item outstanding", $realtime);
        n_errors++;
      end else begin
        want = expected_outcomes.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
        if (overflow_o !== want.overflow)
          report_mismatch("overflow", overflow_o, want.overflow);
        if (node_count_o !== want.count)
          report_mismatch("node_count", node_count_o, want.count);
      end
      n_returned <= n_returned + 1;
    end
  end

  task automatic add_item(logic [1:0] mode, logic [KeyBits-1:0] k);
    pending_ops.push_back('{1'b0, '0, mode, k});
    if (mode == ModeInsert) begin
      seen_keys.push_back(k);
      if (seen_keys.size() > 64) void'(seen_keys.pop_front());
    end
  endtask

  task automatic add_cfg(int v);
    pending_ops.push_back('{1'b1, v[CfgW-1:0], ModeInsert, '0});
  endtask

  function automatic logic [KeyBits-1:0] pick_key();
    if (seen_keys.size() > 0 && $urandom_range(99) < 55)
      return seen_keys[$urandom_range(seen_keys.size() - 1)];
    return $urandom();
  endfunction

  task automatic add_random_items(int n, int clear_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) add_item(ModeInsert, pick_key());
      else if (r < 100 - clear_pct - 3) add_item(ModeFind, pick_key());
      else if (r < 100 - clear_pct) add_item(ModeUnused, $urandom());
      else add_item(ModeClear, $urandom());
    end
  endtask

  initial begin
    int choices[10];
    choices = '{0, 1, 2, 7, 97, 255, 256, 257, 511, 0};
    // Directed part, first under the reset bucket count.
    add_item(ModeFind, 32'd0);
    add_item(ModeInsert, 32'd0);
    add_item(ModeInsert, 32'hFFFF_FFFF);
    add_item(ModeFind, 32'hFFFF_FFFF);
    add_item(ModeInsert, 32'd0);
    add_item(ModeInsert, 32'd97);
    add_item(ModeFind, 32'd0);
    add_item(ModeFind, 32'd194);
    add_item(ModeUnused, 32'hA5A5_5A5A);
    add_item(ModeClear, 32'hFFFF_FFFF);
    add_item(ModeFind, 32'd0);
    // A zero bucket count behaves as a single bucket.
    add_cfg(0);
    add_item(ModeInsert, 32'd12345);
    add_item(ModeInsert, 32'd7);
    add_item(ModeFind, 32'd12345);
    add_item(ModeFind, 32'd8);
    // Counts above the table size saturate; keys stay put when it changes.
    add_cfg(511);
    add_item(ModeInsert, 32'd300);
    add_item(ModeFind, 32'd300);
    add_cfg(97);
    add_item(ModeFind, 32'd300);
    add_item(ModeFind, 32'd12345);
    add_item(ModeClear, 32'd0);
    // Fill the pool until inserts overflow.
    add_cfg(256);
    for (int i = 0; i < PoolNodes + 4; i++) add_item(ModeInsert, $urandom());
    for (int i = 0; i < 8; i++) add_item(ModeFind, pick_key());
    add_item(ModeClear, 32'd0);
    add_item(ModeInsert, 32'd1);
    // Random phases across a range of bucket counts.
    for (int p = 0; p < 10; p++) begin
      choices[9] = $urandom_range(1, 511);
      add_cfg(choices[p]);
      add_random_items(p < 2 ? 60 : 90, 6);
    end
    add_cfg(97);
    add_random_items(50, 6);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stimulus_done && n_taken == n_returned && expected_outcomes.size() == 0);
    repeat (50) @(posedge clk_i);
    if (n_errors == 0 && expected_outcomes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: chained_hash_set.f
rtl/chs_pkg.sv
rtl/chs_front.sv
rtl/chs_queue.sv
rtl/chs_back.sv
rtl/chained_hash_set.sv
dv/tb_chained_hash_set.sv
